[rtl/irc_pkg.sv]
// Package for the impulse response to cepstrum block: sizes, status codes.
// No dependencies; used by impulse_response_to_cepstrum.
package irc_pkg;
   localparam int MaxOrderDefault = 63;
   localparam int FracBitsDefault = 24;
   localparam int DataW = 32;
   localparam int OrderW = 6;
   localparam int StatusW = 2;
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_MISMATCH = 2'd1,
      ST_BAD_H0   = 2'd2
   } status_type;
   localparam logic CSR_INPUT_ORDER = 1'b0;
   localparam logic CSR_OUTPUT_ORDER = 1'b1;
   localparam logic [63:0] Ln2Q28 = 64'd186065279;
   localparam logic signed [63:0] S64Max = 64'sh7FFF_FFFF_FFFF_FFFF;
endpackage

[rtl/impulse_response_to_cepstrum.sv]
// Impulse response to cepstrum converter, top level.
// Depends on irc_pkg and irc_ram.
//
// Usage:
//  - req_ channel: one impulse-response sample per request, tdata = sample
//    (Q8.24 signed), tlast marks the final sample h[M] of a frame.
//  - csr_ port: index 0 writes input_order M, index 1 writes output_order N.
//    Write only while the block is idle.
//  - rsp_ channel: N+1 coefficients c[0..N] in order, tlast on c[N]; tuser
//    carries the status. A bad frame (length != M+1, order > MAX_ORDER or
//    h0 <= 0) yields one reply: coefficient 0, index 0, tlast, nonzero status.
//  - Samples are taken one per cycle while no response is pending. After
//    tlast the request side is held off while the block computes: the log
//    unit finds the leading one bit by bit, runs 30 squaring steps on one
//    32x32 multiplier and stores c[0]; each c[n] needs a multiply-accumulate
//    loop through the two memories and then the radix-2 divider. The
//    coefficients are emitted in order when the receiver takes them; a
//    stalled receiver holds the output register and the whole block.
//  - Reset (synchronous, active high) clears the control state, the sample
//    count and both order registers. Memories are not cleared.
module impulse_response_to_cepstrum
   import irc_pkg::*;
#(
   parameter int MAX_ORDER = MaxOrderDefault,
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [irc_pkg::DataW-1:0] req_tdata,  // [31:0] sample
   input  logic                      req_tlast,  // last
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [39:0]               rsp_tdata,  // [31:0] coefficient, [37:32] coef_index
   output logic                      rsp_tlast,  // final_res
   output logic [1:0]                rsp_tuser,  // [1:0] status
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [irc_pkg::OrderW-1:0] csr_wdata
);
   import irc_pkg::*;

   localparam int AW = $clog2(MAX_ORDER + 1);
   localparam int NW = AW + 1;

   typedef enum logic [10:0] {
      S_LOAD  = 11'b00000000001,
      S_LOG   = 11'b00000000010,
      S_LOGM  = 11'b00000000100,
      S_LOGF  = 11'b00000001000,
      S_NINIT = 11'b00000010000,
      S_MRD   = 11'b00000100000,
      S_MMUL  = 11'b00001000000,
      S_MACC  = 11'b00010000000,
      S_DIV   = 11'b00100000000,
      S_OUT   = 11'b01000000000,
      S_ERR   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [OrderW-1:0] m_ff, n_ff;
   logic [6:0] cnt_ff, cnt_in;

   // memories
   logic          hw_en, cw_en;
   logic [AW-1:0] hw_addr, cw_addr, hr_addr, cr_addr;
   logic [31:0]   hw_data, cw_data, hr_data, cr_data;

   irc_ram #(.Width(DataW), .Depth(MAX_ORDER + 1)) u_hram (
      .clock, .wr_en(hw_en), .wr_addr(hw_addr), .wr_data(hw_data),
      .rd_addr(hr_addr), .rd_data(hr_data));
   irc_ram #(.Width(DataW), .Depth(MAX_ORDER + 1)) u_cram (
      .clock, .wr_en(cw_en), .wr_addr(cw_addr), .wr_data(cw_data),
      .rd_addr(cr_addr), .rd_data(cr_data));

   // working registers
   logic signed [31:0] h0_ff, h0_in;
   logic [63:0] lm_ff, lm_in;       // log mantissa
   logic [29:0] lfr_ff, lfr_in;
   logic [4:0]  lp_ff, lp_in;       // msb position
   logic [4:0]  lstep_ff, lstep_in;
   logic [NW-1:0] n_idx_ff, n_idx_in;
   logic [NW-1:0] k_ff, k_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] den_ff, den_in;
   logic        dneg_ff, dneg_in;
   logic [6:0]  dstep_ff, dstep_in;
   logic        rd_ok_ff, rd_ok_in;
   logic [NW-1:0] o_idx_ff, o_idx_in;
   logic        ov_ff, ov_in;
   logic [31:0] oc_ff, oc_in;
   logic [OrderW-1:0] oi_ff, oi_in;
   logic        ol_ff, ol_in;
   logic [1:0]  os_ff, os_in;

   // saturating helpers
   function automatic logic signed [63:0] sat_scale(input logic signed [63:0] a,
                                                   input logic [NW-1:0] k);
      logic signed [127:0] p;
      p = a * $signed({1'b0, k});
      if (p > $signed({{64{1'b0}}, S64Max})) return S64Max;
      if (p < -$signed({{64{1'b0}}, S64Max})) return -S64Max;
      return p[63:0];
   endfunction

   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s > $signed({1'b0, S64Max})) return S64Max;
      if (s < -$signed({1'b0, S64Max})) return -S64Max;
      return s[63:0];
   endfunction

   logic [63:0] sq;
   logic signed [37:0] lval;
   logic [37:0] lmag;
   logic [127:0] lprod;
   logic [63:0] lr;
   logic signed [31:0] lres;
   logic [NW-1:0] begin_k;
   logic [64:0] rtry;
   logic signed [64:0] qs;
   logic [31:0] qres;
   logic frame_bad;
   logic [6:0] cnt_next;

   assign sq = lm_ff[31:0] * lm_ff[31:0];
   assign lval = ($signed({1'b0, {1'b0, lp_ff}}) - 38'sd0 - FRAC_BITS) * 38'sd1073741824
                 + $signed({8'd0, lfr_ff});
   assign lmag = lval[37] ? -lval : lval;
   assign lprod = lmag * Ln2Q28;
   assign lr = 64'((lprod + (128'd1 << (57 - FRAC_BITS))) >> (58 - FRAC_BITS));
   always_comb begin
      if (lval[37]) begin
         lres = (lr >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(-$signed(lr));
      end else begin
         lres = (lr > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : lr[31:0];
      end
   end

   assign begin_k = ({2'b0, m_ff} < n_idx_ff) ? NW'(n_idx_ff - {2'b0, m_ff}) : NW'(1);
   assign rtry = {rem_ff[63:0], quo_ff[63]} - {1'b0, den_ff};
   assign qs = dneg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   always_comb begin
      if (qs > 65'sh7FFF_FFFF) qres = 32'h7FFF_FFFF;
      else if (qs < -65'sh8000_0000) qres = 32'h8000_0000;
      else qres = qs[31:0];
   end
   assign cnt_next = (cnt_ff < 7'd127) ? cnt_ff + 7'd1 : 7'd127;
   assign frame_bad = (cnt_next != {1'b0, m_ff} + 7'd1) || (m_ff > MAX_ORDER)
                      || (n_ff > MAX_ORDER);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         cnt_ff   <= '0;
         m_ff     <= '0;
         n_ff     <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ov_ff    <= ov_in;
         if (csr_wr_en && csr_index == CSR_INPUT_ORDER) m_ff <= csr_wdata;
         if (csr_wr_en && csr_index == CSR_OUTPUT_ORDER) n_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      h0_ff <= h0_in; lm_ff <= lm_in; lfr_ff <= lfr_in; lp_ff <= lp_in;
      lstep_ff <= lstep_in; n_idx_ff <= n_idx_in; k_ff <= k_in;
      acc_ff <= acc_in; prod_ff <= prod_in; rem_ff <= rem_in; quo_ff <= quo_in;
      den_ff <= den_in; dneg_ff <= dneg_in; dstep_ff <= dstep_in;
      rd_ok_ff <= rd_ok_in; o_idx_ff <= o_idx_in; oc_ff <= oc_in;
      oi_ff <= oi_in; ol_ff <= ol_in; os_ff <= os_in;
   end

   assign req_tready = (state_ff == S_LOAD) && !ov_ff;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {2'b0, oi_ff, oc_ff};
   assign rsp_tlast  = ol_ff;
   assign rsp_tuser  = os_ff;

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff;
      h0_in = h0_ff; lm_in = lm_ff; lfr_in = lfr_ff; lp_in = lp_ff;
      lstep_in = lstep_ff; n_idx_in = n_idx_ff; k_in = k_ff; acc_in = acc_ff;
      prod_in = prod_ff; rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff;
      dneg_in = dneg_ff; dstep_in = dstep_ff; rd_ok_in = rd_ok_ff;
      o_idx_in = o_idx_ff; ov_in = ov_ff; oc_in = oc_ff; oi_in = oi_ff;
      ol_in = ol_ff; os_in = os_ff;
      hw_en = 1'b0; hw_addr = cnt_ff[AW-1:0]; hw_data = req_tdata;
      cw_en = 1'b0; cw_addr = '0; cw_data = lres;
      hr_addr = '0; cr_addr = '0;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      case (state_ff)
         S_LOAD: begin
            if (req_tvalid && req_tready) begin
               // store sample; index 0 is also kept as h0
               hw_en = (cnt_ff <= MAX_ORDER);
               if (cnt_ff == 7'd0) h0_in = req_tdata;
               if (!req_tlast) begin
                  cnt_in = cnt_next;
               end else begin
                  cnt_in = '0;
                  if (frame_bad) begin
                     os_in = ST_MISMATCH; state_in = S_ERR;
                  end else if ((cnt_ff == 7'd0 ? $signed(req_tdata) : h0_ff) <= 0) begin
                     os_in = ST_BAD_H0; state_in = S_ERR;
                  end else begin
                     if (cnt_ff == 7'd0) lm_in = {32'd0, req_tdata};
                     else lm_in = {32'd0, h0_ff};
                     lp_in = 5'd30; lstep_in = '0; lfr_in = '0;
                     state_in = S_LOGM;
                  end
               end
            end
         end
         S_LOGM: begin
            // normalize: find msb one bit per cycle
            if (lm_ff[lp_ff] || lp_ff == 5'd0) begin
               lm_in = 64'(lm_ff << (5'd30 - lp_ff));
               state_in = S_LOG;
            end else begin
               lp_in = lp_ff - 5'd1;
            end
         end
         S_LOG: begin
            // one squaring step
            lm_in = sq >> 30;
            lfr_in = {lfr_ff[28:0], 1'b0};
            if (lm_in >= 64'h8000_0000) begin
               lm_in = lm_in >> 1;
               lfr_in[0] = 1'b1;
            end
            lstep_in = lstep_ff + 5'd1;
            if (lstep_ff == 5'd29) state_in = S_LOGF;
         end
         S_LOGF: begin
            cw_en = 1'b1; cw_addr = '0; cw_data = lres;
            n_idx_in = NW'(1);
            o_idx_in = '0;
            rd_ok_in = 1'b0;
            state_in = (n_ff == '0) ? S_OUT : S_NINIT;
         end
         S_NINIT: begin
            hr_addr = n_idx_ff[AW-1:0];
            k_in = begin_k;
            acc_in = '0;
            rd_ok_in = (n_idx_ff <= {1'b0, m_ff});
            state_in = S_MRD;
            prod_in = '0;
            dstep_in = '0;
            if (rd_ok_in) dstep_in = 7'd1;
         end
         S_MRD: begin
            if (dstep_ff == 7'd1) begin
               // n*h[n] scaled by 2^FRAC_BITS
               acc_in = sat_scale($signed({{32{hr_data[31]}}, hr_data}) <<< FRAC_BITS,
                                  n_idx_ff);
               dstep_in = '0;
            end
            if (k_ff < n_idx_ff) begin
               cr_addr = k_ff[AW-1:0];
               hr_addr = AW'(n_idx_ff - k_ff);
               state_in = S_MMUL;
            end else begin
               den_in = 64'(n_idx_ff) * 64'(h0_ff);
               dneg_in = acc_in[63];
               quo_in = acc_in[63] ? 64'(-acc_in) : 64'(acc_in);
               rem_in = '0;
               dstep_in = '0;
               state_in = S_DIV;
            end
         end
         S_MMUL: begin
            prod_in = $signed(cr_data) * $signed(hr_data);
            state_in = S_MACC;
         end
         S_MACC: begin
            acc_in = sat_sub(acc_ff, sat_scale(prod_ff, k_ff));
            k_in = k_ff + NW'(1);
            dstep_in = '0;
            state_in = S_MRD;
         end
         S_DIV: begin
            // restoring division, one quotient bit per cycle
            if (dstep_ff == 7'd0) begin
               quo_in = quo_ff + (den_ff >> 1);
               dstep_in = 7'd1;
            end else begin
               if (!rtry[64]) rem_in = rtry[63:0];
               else rem_in = {rem_ff[62:0], quo_ff[63]};
               quo_in = {quo_ff[62:0], !rtry[64]};
               dstep_in = dstep_ff + 7'd1;
               if (dstep_ff == 7'd65) begin
                  cw_en = 1'b1; cw_addr = n_idx_ff[AW-1:0]; cw_data = qres;
                  quo_in = quo_ff;
                  if (n_idx_ff == {1'b0, n_ff}) begin
                     state_in = S_OUT;
                  end else begin
                     n_idx_in = n_idx_ff + NW'(1);
                     state_in = S_NINIT;
                  end
               end
            end
         end
         S_OUT: begin
            cr_addr = o_idx_ff[AW-1:0];
            if (!ov_ff || rsp_tready) begin
               if (rd_ok_ff) begin
                  ov_in = 1'b1; oc_in = cr_data; oi_in = o_idx_ff[OrderW-1:0];
                  ol_in = (o_idx_ff == {1'b0, n_ff}); os_in = ST_OK;
                  rd_ok_in = 1'b0;
                  if (o_idx_ff == {1'b0, n_ff}) state_in = S_LOAD;
                  else o_idx_in = o_idx_ff + NW'(1);
               end else begin
                  rd_ok_in = 1'b1;
               end
               cr_addr = rd_ok_ff ? o_idx_in[AW-1:0] : o_idx_ff[AW-1:0];
               if (rd_ok_ff) rd_ok_in = 1'b0;
            end
         end
         S_ERR: begin
            if (!ov_ff || rsp_tready) begin
               ov_in = 1'b1; oc_in = '0; oi_in = '0; ol_in = 1'b1;
               state_in = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end
endmodule

[rtl/irc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module irc_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
